[hdl/kf3_pkg.sv]
// Shared types, constants and helpers of the three-axis position Kalman filter.
package kf3_pkg;

  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned EST_W      = 48;
  localparam int unsigned VAR_W      = 64;
  localparam int unsigned SIGMA_W    = 32;
  localparam int unsigned GAIN_W     = 25;
  localparam int unsigned DIV_STEPS  = 24;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned MUL_OPS    = 12;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned ADDR_W     = 6;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned IDX_W      = 3;

  localparam logic [VAR_W-1:0]  PNOISE_RST = 64'd16777;
  localparam logic [VAR_W-1:0]  MNOISE_RST = 64'd419430400;
  localparam logic [VAR_W-1:0]  IVAR_RST   = 64'd16777216;
  localparam logic [GAIN_W-1:0] ONE_Q24    = 25'd16777216;

  // register indexes
  localparam logic [IDX_W-1:0] REG_PN0  = 3'd0;
  localparam logic [IDX_W-1:0] REG_PN1  = 3'd1;
  localparam logic [IDX_W-1:0] REG_PN2  = 3'd2;
  localparam logic [IDX_W-1:0] REG_MN0  = 3'd3;
  localparam logic [IDX_W-1:0] REG_MN1  = 3'd4;
  localparam logic [IDX_W-1:0] REG_MN2  = 3'd5;
  localparam logic [IDX_W-1:0] REG_IVAR = 3'd6;
  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic signed [EST_W-1:0] meas_axis2;
    logic signed [EST_W-1:0] meas_axis1;
    logic signed [EST_W-1:0] meas_axis0;
  } meas_t;

  typedef struct packed {
    logic [SIGMA_W-1:0]      sigma_axis2;
    logic [SIGMA_W-1:0]      sigma_axis1;
    logic [SIGMA_W-1:0]      sigma_axis0;
    logic signed [EST_W-1:0] est_axis2;
    logic signed [EST_W-1:0] est_axis1;
    logic signed [EST_W-1:0] est_axis0;
  } est_t;

  // noise settings of one lane
  typedef struct packed {
    logic [VAR_W-1:0] pnoise;
    logic [VAR_W-1:0] mnoise;
  } lane_cfg_t;

  // what one lane hands to the merge stage
  typedef struct packed {
    logic signed [EST_W-1:0] est;
    logic [SIGMA_W-1:0]      sigma;
  } lane_res_t;

  typedef enum logic [2:0] {
    LS_IDLE, LS_SUM, LS_ITER, LS_GAIN, LS_MUL, LS_FIN
  } lane_state_e;

  typedef enum logic [1:0] {
    TS_IDLE, TS_RUN, TS_HOLD
  } top_state_e;

  // saturating 64-bit add
  function automatic logic [VAR_W-1:0] sat_add(input logic [VAR_W-1:0] a,
                                              input logic [VAR_W-1:0] b);
    logic [VAR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VAR_W] ? '1 : s[VAR_W-1:0];
  endfunction

endpackage

[hdl/kalman_filter_three_axis_position_core.sv]
// Each item runs the sqrt loop of 32 steps and then 12 multiplies in every lane.
// All lanes run in lockstep on one item at a time; a new item is taken only after the last result is loaded out.
// The sqrt/divide unit and the single 32x25 multiplier of each lane set the time that an item takes.
// A finished result sits in the output register while the next item is taken in.
// Reset: estimates clear to zero, variances load the initial-variance reset value.
// Reset: noise registers take their reset values; no item or result is pending.
module kalman_filter_three_axis_position_core import kf3_pkg::*; #(
  parameter int unsigned Axes = NUM_AXES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  meas_t             in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output est_t              out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // configuration registers
  logic [VAR_W-1:0] pn_q [NUM_AXES];
  logic [VAR_W-1:0] mn_q [NUM_AXES];
  logic [VAR_W-1:0] ivar_q;
  logic [IDX_W-1:0] idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:3];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        pn_q[i] <= PNOISE_RST;
        mn_q[i] <= MNOISE_RST;
      end
      ivar_q <= IVAR_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_PN0:  pn_q[0] <= pwdata;
        REG_PN1:  pn_q[1] <= pwdata;
        REG_PN2:  pn_q[2] <= pwdata;
        REG_MN0:  mn_q[0] <= pwdata;
        REG_MN1:  mn_q[1] <= pwdata;
        REG_MN2:  mn_q[2] <= pwdata;
        REG_IVAR: ivar_q  <= pwdata;
        default:  ivar_q  <= ivar_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PN0:  prdata = pn_q[0];
      REG_PN1:  prdata = pn_q[1];
      REG_PN2:  prdata = pn_q[2];
      REG_MN0:  prdata = mn_q[0];
      REG_MN1:  prdata = mn_q[1];
      REG_MN2:  prdata = mn_q[2];
      REG_IVAR: prdata = ivar_q;
      REG_NONE: prdata = '0;
      default:  prdata = '0;
    endcase
  end

  logic load_var;
  assign load_var = wr_en && (idx == REG_IVAR);

  // control
  top_state_e state_q, state_d;
  logic       start, load_out, lane_done;
  logic       out_valid_q, out_valid_d;
  est_t       out_q;

  assign start    = (state_q == TS_IDLE) && in_valid_i;
  assign load_out = (state_q == TS_HOLD) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      TS_IDLE: if (in_valid_i) state_d = TS_RUN;
      TS_RUN:  if (lane_done)  state_d = TS_HOLD;
      TS_HOLD: if (load_out)   state_d = TS_IDLE;
      default: state_d = TS_IDLE;
    endcase
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != TS_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // lanes
  logic [EST_W-1:0] meas [NUM_AXES];
  lane_res_t        res  [NUM_AXES];
  logic [NUM_AXES-1:0] done;

  assign meas[0] = in_data_i.meas_axis0;
  assign meas[1] = in_data_i.meas_axis1;
  assign meas[2] = in_data_i.meas_axis2;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    if (a < Axes) begin : g_on
      lane_cfg_t cfg;
      assign cfg.pnoise = pn_q[a];
      assign cfg.mnoise = mn_q[a];
      kf3_lane u_lane (
        .clk_i,
        .rst_ni,
        .start_i    (start),
        .meas_i     (meas[a]),
        .cfg_i      (cfg),
        .load_i     (load_var),
        .init_var_i (pwdata),
        .done_o     (done[a]),
        .res_o      (res[a])
      );
    end else begin : g_off
      assign done[a] = 1'b0;
      assign res[a]  = '0;
    end
  end

  assign lane_done = done[0];

  // merge lane results into the output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.est_axis0   <= res[0].est;
      out_q.est_axis1   <= res[1].est;
      out_q.est_axis2   <= res[2].est;
      out_q.sigma_axis0 <= res[0].sigma;
      out_q.sigma_axis1 <= res[1].sigma;
      out_q.sigma_axis2 <= res[2].sigma;
    end
  end

  // checks
  a_done_when_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_done |-> (state_q == TS_RUN))
    else $error("lane finished outside of a run");

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == TS_RUN))
    else $error("accepted item did not start the lanes");

  a_out_from_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == TS_HOLD))
    else $error("result shown without finished lanes");

  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_done |-> ($countones(done) == Axes))
    else $error("lanes out of step");

endmodule

[hdl/kf3_lane.sv]
// One scalar Kalman filter lane: shared iterative sqrt/divide, then a multiply sequencer.
module kf3_lane import kf3_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [EST_W-1:0] meas_i,
  input  lane_cfg_t        cfg_i,
  input  logic             load_i,
  input  logic [VAR_W-1:0] init_var_i,
  output logic             done_o,
  output lane_res_t        res_o
);

  lane_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic signed [EST_W-1:0] est_q;
  logic [VAR_W-1:0]   var_q;
  logic signed [EST_W-1:0] z_q;
  logic [VAR_W-1:0]   p1_q, s_q, rem_q, sv_q, root_q, bit_q;
  logic [DIV_STEPS-1:0] quo_q;
  logic [SIGMA_W-1:0] sigma_q;
  logic [GAIN_W-1:0]  k_q, nk_q;
  logic [VAR_W-1:0]   a_q, tmp_q, v1_q, t_q, u_q;
  logic [EST_W:0]     d_q;
  logic               neg_q;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      LS_IDLE: begin
        if (start_i) begin
          state_d = LS_SUM;
        end
      end
      LS_SUM: begin
        state_d = LS_ITER;
        cnt_d   = '0;
      end
      LS_ITER: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SQRT_STEPS - 2)) begin
          state_d = LS_GAIN;
        end
      end
      LS_GAIN: begin
        state_d = LS_MUL;
        cnt_d   = '0;
      end
      LS_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MUL_OPS - 1)) begin
          state_d = LS_FIN;
        end
      end
      LS_FIN:  state_d = LS_IDLE;
      default: state_d = LS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LS_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // square root step: restoring, two bits per cycle
  logic [VAR_W-1:0] trial;
  assign trial = root_q + bit_q;

  // fractional divide step
  logic [VAR_W-1:0] rem_sh;
  logic             rem_take;
  assign rem_sh   = {rem_q[VAR_W-2:0], 1'b0};
  assign rem_take = rem_q[VAR_W-1] || (rem_sh >= s_q);

  // shared 32x25 multiplier, operands picked by the op count
  logic [31:0]        mul_a;
  logic [GAIN_W-1:0]  mul_b;
  logic [56:0]        prod;
  always_comb begin
    unique case (cnt_q[3:0])
      4'd0:    begin mul_a = p1_q[63:32]; mul_b = nk_q; end
      4'd1:    begin mul_a = p1_q[31:0];  mul_b = nk_q; end
      4'd2:    begin mul_a = a_q[63:32];  mul_b = nk_q; end
      4'd3:    begin mul_a = a_q[31:0];   mul_b = nk_q; end
      4'd4:    begin mul_a = cfg_i.mnoise[63:32]; mul_b = k_q; end
      4'd5:    begin mul_a = cfg_i.mnoise[31:0];  mul_b = k_q; end
      4'd6:    begin mul_a = a_q[63:32];  mul_b = k_q; end
      4'd7:    begin mul_a = a_q[31:0];   mul_b = k_q; end
      4'd8:    begin mul_a = d_q[31:0];   mul_b = GAIN_W'(k_q[11:0]); end
      4'd9:    begin mul_a = 32'(d_q[EST_W:32]); mul_b = GAIN_W'(k_q[11:0]); end
      4'd10:   begin mul_a = d_q[31:0];   mul_b = GAIN_W'(k_q[24:12]); end
      4'd11:   begin mul_a = 32'(d_q[EST_W:32]); mul_b = GAIN_W'(k_q[24:12]); end
      default: begin mul_a = '0;          mul_b = '0; end
    endcase
  end
  assign prod = 57'(mul_a) * 57'(mul_b);

  logic [VAR_W-1:0] hi_part, lo_part, wide_lo;
  assign hi_part = {prod[55:0], 8'b0};
  assign lo_part = 64'(prod[56:24]);
  assign wide_lo = {prod[31:0], 32'b0};

  // rounding of the correction term
  logic [VAR_W-1:0] delta, rnd;
  assign rnd   = {40'b0, u_q[11:0], 12'b0} + t_q + 64'h800000;
  assign delta = {12'b0, u_q[63:12]} + {24'b0, rnd[63:24]};

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      LS_IDLE: begin
        if (start_i) begin
          z_q    <= meas_i;
          p1_q   <= sat_add(var_q, cfg_i.pnoise);
          sv_q   <= var_q;
          root_q <= '0;
          bit_q  <= 64'h4000_0000_0000_0000;
        end
      end
      LS_SUM, LS_ITER: begin
        if (sv_q >= trial) begin
          sv_q   <= sv_q - trial;
          root_q <= {1'b0, root_q[VAR_W-1:1]} + bit_q;
        end else begin
          root_q <= {1'b0, root_q[VAR_W-1:1]};
        end
        bit_q <= {2'b0, bit_q[VAR_W-1:2]};
        if (state_q == LS_SUM) begin
          s_q   <= sat_add(p1_q, cfg_i.mnoise);
          rem_q <= p1_q;
          quo_q <= '0;
        end else if (cnt_q < CNT_W'(DIV_STEPS)) begin
          rem_q <= rem_take ? rem_sh - s_q : rem_sh;
          quo_q <= {quo_q[DIV_STEPS-2:0], rem_take};
        end
      end
      LS_GAIN: begin
        sigma_q <= root_q[SIGMA_W-1:0];
        if (s_q == '0) begin
          k_q  <= '0;
          nk_q <= ONE_Q24;
        end else if (p1_q >= s_q) begin
          k_q  <= ONE_Q24;
          nk_q <= '0;
        end else begin
          k_q  <= GAIN_W'(quo_q);
          nk_q <= ONE_Q24 - GAIN_W'(quo_q);
        end
        if (z_q >= est_q) begin
          d_q   <= (EST_W+1)'(z_q) - (EST_W+1)'(est_q);
          neg_q <= 1'b0;
        end else begin
          d_q   <= (EST_W+1)'(est_q) - (EST_W+1)'(z_q);
          neg_q <= 1'b1;
        end
      end
      LS_MUL: begin
        unique case (cnt_q[3:0])
          4'd0, 4'd2, 4'd4, 4'd6: tmp_q <= hi_part;
          4'd1, 4'd5, 4'd7:       a_q   <= tmp_q + lo_part;
          4'd3:                   v1_q  <= tmp_q + lo_part;
          4'd8:                   t_q   <= 64'(prod);
          4'd9:                   t_q   <= t_q + wide_lo;
          4'd10:                  u_q   <= 64'(prod);
          4'd11:                  u_q   <= u_q + wide_lo;
          default:                tmp_q <= tmp_q;
        endcase
      end
      default: begin
      end
    endcase
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= '0;
      var_q <= IVAR_RST;
    end else if (load_i) begin
      var_q <= init_var_i;
    end else if (state_q == LS_FIN) begin
      var_q <= sat_add(v1_q, a_q);
      est_q <= neg_q ? est_q - EST_W'(delta) : est_q + EST_W'(delta);
    end
  end

  assign done_o    = (state_q == LS_FIN);
  assign res_o.est   = est_q;
  assign res_o.sigma = sigma_q;

endmodule

[sim/tb_kalman_filter_three_axis_position_core.sv]
// Self-checking testbench for the three-axis position Kalman filter core.
`timescale 1ns / 100ps

module tb_kalman_filter_three_axis_position_core;
  import kf3_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_PER_PHASE = 190;
  localparam int NUM_PHASES     = 8;

  // Per-axis filter state and expected estimates, kept beside the DUT
  class fix_tracker;
    logic [VAR_W-1:0]        pnoise [NUM_AXES];
    logic [VAR_W-1:0]        mnoise [NUM_AXES];
    logic [VAR_W-1:0]        ivar;
    logic signed [EST_W-1:0] track [NUM_AXES];
    logic [VAR_W-1:0]        var_q [NUM_AXES];
    est_t                    pending_est [$];
    int                      mismatch_cnt;

    function void clear();
      ivar = IVAR_RST;
      for (int a = 0; a < NUM_AXES; a++) begin
        pnoise[a] = PNOISE_RST;
        mnoise[a] = MNOISE_RST;
        track[a]  = '0;
        var_q[a]  = IVAR_RST;
      end
      pending_est.delete();
      mismatch_cnt = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [VAR_W-1:0] val);
      if (idx <= REG_PN2) pnoise[idx] = val;
      else if (idx <= REG_MN2) mnoise[idx - REG_MN0] = val;
      else if (idx == REG_IVAR) begin
        ivar = val;
        for (int a = 0; a < NUM_AXES; a++) var_q[a] = val;
      end
    endfunction

    function logic [VAR_W-1:0] add_sat(logic [VAR_W-1:0] a, logic [VAR_W-1:0] b);
      logic [VAR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[VAR_W] ? '1 : s[VAR_W-1:0];
    endfunction

    // floor(a * f / 2^24)
    function logic [VAR_W-1:0] times_q24(logic [VAR_W-1:0] a, logic [VAR_W-1:0] f);
      logic [127:0] w;
      w = {64'd0, a} * {64'd0, f};
      return w[87:24];
    endfunction

    function logic [SIGMA_W-1:0] floor_root(logic [VAR_W-1:0] v);
      logic [SIGMA_W-1:0] r;
      logic [SIGMA_W-1:0] t;
      r = '0;
      for (int i = SIGMA_W - 1; i >= 0; i--) begin
        t = r | (32'd1 << i);
        if ({32'd0, t} * {32'd0, t} <= v) r = t;
      end
      return r;
    endfunction

    // one accepted fix: run all three scalar filters
    function void take_fix(meas_t m);
      logic [VAR_W-1:0]        p, r, p1, s, k, nk, d, delta;
      logic [127:0]            w;
      logic signed [EST_W-1:0] z, x;
      logic [SIGMA_W-1:0]      sg [NUM_AXES];
      est_t                    e;
      for (int a = 0; a < NUM_AXES; a++) begin
        z = m[a*EST_W +: EST_W];
        x = track[a];
        p = var_q[a];
        r = mnoise[a];
        sg[a] = floor_root(p);
        p1 = add_sat(p, pnoise[a]);
        s  = add_sat(p1, r);
        if (s == 0) k = 0;
        else if (p1 >= s) k = 64'd16777216;
        else begin
          w = {p1, 24'd0};
          k = 64'(w / {64'd0, s});
        end
        nk = 64'd16777216 - k;
        if (z >= x) d = 64'(longint'(z) - longint'(x));
        else d = 64'(longint'(x) - longint'(z));
        w = {64'd0, d} * {64'd0, k} + (128'd1 << 23);
        delta = w[87:24];
        if (z >= x) x = x + EST_W'(delta);
        else x = x - EST_W'(delta);
        track[a] = x;
        var_q[a] = add_sat(times_q24(times_q24(p1, nk), nk),
                           times_q24(times_q24(r, k), k));
      end
      e.est_axis0 = track[0];
      e.est_axis1 = track[1];
      e.est_axis2 = track[2];
      e.sigma_axis0 = sg[0];
      e.sigma_axis1 = sg[1];
      e.sigma_axis2 = sg[2];
      pending_est.push_back(e);
    endfunction

    function void flag(string what, logic [63:0] exp_v, logic [63:0] act_v);
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("mismatch %s: expected %h actual %h", what, exp_v, act_v);
    endfunction

    function void check_est(est_t got);
      est_t want;
      if (pending_est.size() == 0) begin
        flag("unexpected result", '0, got[63:0]);
        return;
      end
      want = pending_est.pop_front();
      if (got.est_axis0 !== want.est_axis0) flag("est_axis0", want.est_axis0, got.est_axis0);
      if (got.est_axis1 !== want.est_axis1) flag("est_axis1", want.est_axis1, got.est_axis1);
      if (got.est_axis2 !== want.est_axis2) flag("est_axis2", want.est_axis2, got.est_axis2);
      if (got.sigma_axis0 !== want.sigma_axis0)
        flag("sigma_axis0", want.sigma_axis0, got.sigma_axis0);
      if (got.sigma_axis1 !== want.sigma_axis1)
        flag("sigma_axis1", want.sigma_axis1, got.sigma_axis1);
      if (got.sigma_axis2 !== want.sigma_axis2)
        flag("sigma_axis2", want.sigma_axis2, got.sigma_axis2);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  meas_t             in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  est_t              out_data_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  fix_tracker        chk;
  bit                idle_on;
  int                hold_left;
  int                stall_left;
  int                quiet_cnt;
  logic signed [EST_W-1:0] base_pos [NUM_AXES];

  kalman_filter_three_axis_position_core u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk_i = ~clk_i;

  // watchdog: cycles without any transfer or register write
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable))
      quiet_cnt <= 0;
    else
      quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= WATCHDOG_LIMIT) begin
      $display("FAIL kalman_filter_three_axis_position_core");
      $finish;
    end
  end

  // result side: check on transfer, stall in bursts and for the long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) chk.check_est(out_data_o);
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [VAR_W-1:0] val);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 3'b000};
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (pready) chk.set_reg(idx, val);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic send_fix(meas_t m);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i = m;
    do @(posedge clk_i); while (in_stall_o);
    chk.take_fix(m);
  endtask

  task automatic input_gap(int n);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // wait for every expected estimate, then let the core go idle
  task automatic drain();
    while (chk.pending_est.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [VAR_W-1:0] pick_noise();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom};
      3: return 64'($urandom_range(0, 32'h4000_0000));
      default: return {24'd0, 8'($urandom), $urandom};
    endcase
  endfunction

  function automatic logic signed [EST_W-1:0] pick_coord(int a);
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return base_pos[a] + EST_W'($signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000);
      4, 5: return {16'($urandom), $urandom};
      6: return {1'b0, {(EST_W-1){1'b1}}};
      default: return {1'b1, {(EST_W-1){1'b0}}};
    endcase
  endfunction

  initial begin
    meas_t m;
    logic signed [EST_W-1:0] mx, mn;
    chk = new();
    chk.clear();
    idle_on = 1'b0;
    hold_left = 0;
    stall_left = 0;
    quiet_cnt = 0;
    mx = {1'b0, {(EST_W-1){1'b1}}};
    mn = {1'b1, {(EST_W-1){1'b0}}};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // settings: reset values, all zero, all saturated, then random
      if (ph > 0) begin
        drain();
        for (int i = 0; i <= REG_IVAR; i++) begin
          if (ph == 1) write_reg(IDX_W'(i), '0);
          else if (ph == 2) write_reg(IDX_W'(i), '1);
          else write_reg(IDX_W'(i), pick_noise());
        end
        if (ph == 1) write_reg(REG_NONE, '1);
      end
      for (int a = 0; a < NUM_AXES; a++) base_pos[a] = {16'($urandom), $urandom};
      idle_on = (ph != 0) && (ph != NUM_PHASES - 1);

      // directed extremes with reset settings
      if (ph == 0) begin
        send_fix({mx, mx, mx});
        send_fix({mn, mn, mn});
        send_fix({48'sd0, 48'sd0, 48'sd0});
        send_fix({mx, mn, 48'sd0});
        send_fix({-48'sd1, 48'sd1, -48'sd1});
        send_fix({mn, mx, mx});
        send_fix({mx, mn, mn});
        send_fix({48'sd1, 48'sd0, -48'sd1});
        for (int i = 0; i < 6; i++) send_fix({mn, mx, mn});
        send_fix('1);
        send_fix({mx, mx, mx});
        send_fix({48'sd0, 48'sd0, 48'sd0});
      end

      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (ph == 1 && n == 20) hold_left = HOLD_CYCLES;
        m.meas_axis0 = pick_coord(0);
        m.meas_axis1 = pick_coord(1);
        m.meas_axis2 = pick_coord(2);
        send_fix(m);
        if (idle_on && $urandom_range(0, 5) == 0) input_gap($urandom_range(1, 16));
      end
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end

    drain();
    if (chk.mismatch_cnt == 0 && chk.pending_est.size() == 0)
      $display("PASS kalman_filter_three_axis_position_core");
    else
      $display("FAIL kalman_filter_three_axis_position_core");
    $finish;
  end

endmodule

[kalman_filter_three_axis_position_core.f]
hdl/kf3_pkg.sv
hdl/kf3_lane.sv
hdl/kalman_filter_three_axis_position_core.sv
sim/tb_kalman_filter_three_axis_position_core.sv
